### src/brvm_pkg.sv
// Package with opcode codes, payload structs and shared types for the byte VM executor.
package brvm_pkg;

  typedef enum logic [4:0] {
    OP_NOP = 5'd0, OP_MOVMR = 5'd1, OP_MOVMW = 5'd2, OP_MOVR = 5'd3, OP_MOVB = 5'd4,
    OP_MOVA = 5'd5, OP_INC = 5'd6, OP_DEC = 5'd7, OP_ADD = 5'd8, OP_SUB = 5'd9,
    OP_MUL = 5'd10, OP_DIV = 5'd11, OP_POP = 5'd12, OP_PUSH = 5'd13, OP_AND = 5'd14,
    OP_OR = 5'd15, OP_XOR = 5'd16, OP_NOT = 5'd17, OP_CMP = 5'd18, OP_CMPR = 5'd19,
    OP_JMP = 5'd20, OP_JE = 5'd21, OP_JNE = 5'd22, OP_JG = 5'd23, OP_JL = 5'd24,
    OP_CALL = 5'd25, OP_RET = 5'd26, OP_CLI = 5'd27, OP_STI = 5'd28, OP_SWI = 5'd29,
    OP_OTHER = 5'd30, OP_OTHER2 = 5'd31
  } op_t;

  localparam logic [7:0] VEC_DISPLAY = 8'h10;
  localparam logic [7:0] VEC_FILESYS = 8'h13;
  localparam logic [7:0] VEC_NETWORK = 8'h14;
  localparam logic [7:0] VEC_OS      = 8'h47;
  localparam logic [7:0] VEC_EXIT    = 8'h20;

  localparam logic [2:0] SVC_NONE    = 3'd0;
  localparam logic [2:0] SVC_DISPLAY = 3'd1;
  localparam logic [2:0] SVC_FILESYS = 3'd2;
  localparam logic [2:0] SVC_NETWORK = 3'd3;
  localparam logic [2:0] SVC_OS      = 3'd4;

  localparam logic CFG_HEAP_BASE  = 1'b0;
  localparam logic CFG_HEAP_LIMIT = 1'b1;

  typedef struct packed {
    logic [4:0]  op;
    logic [2:0]  dst;
    logic [2:0]  src_one;
    logic [2:0]  src_two;
    logic [7:0]  imm_low;
    logic [7:0]  imm_high;
    logic [31:0] target;
    logic [7:0]  vector_byte;
    logic [7:0]  load_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        mem_read;
    logic        mem_write;
    logic [31:0] mem_address;
    logic [7:0]  store_data;
    logic        seg_fault;
    logic        irq_enable;
    logic [2:0]  service;
    logic        exit_to_host;
    logic        program_end;
  } out_item_t;

  // Instruction classified by the front end.
  typedef struct packed {
    in_item_t item;
    logic     is_mem;
    logic     is_div;
    logic [2:0] svc;
    logic     ext;
  } dec_item_t;

endpackage

### src/brvm_front.sv
// Front end: accepts instructions, classifies them and feeds a two-entry queue.
module brvm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  brvm_pkg::in_item_t  in_data,
  output logic                q_valid,
  input  logic                q_pop,
  output brvm_pkg::dec_item_t q_data
);

  brvm_pkg::dec_item_t q_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  brvm_pkg::dec_item_t dec;
  logic push;
  logic pop;

  // Classification of the incoming item.
  always_comb begin
    dec = '0;
    dec.item = in_data;
    dec.is_mem = (in_data.op == brvm_pkg::OP_MOVMR) || (in_data.op == brvm_pkg::OP_MOVMW);
    dec.is_div = (in_data.op == brvm_pkg::OP_DIV);
    dec.svc = brvm_pkg::SVC_NONE;
    if (in_data.op == brvm_pkg::OP_SWI) begin
      case (in_data.vector_byte)
        brvm_pkg::VEC_DISPLAY: dec.svc = brvm_pkg::SVC_DISPLAY;
        brvm_pkg::VEC_FILESYS: dec.svc = brvm_pkg::SVC_FILESYS;
        brvm_pkg::VEC_NETWORK: dec.svc = brvm_pkg::SVC_NETWORK;
        brvm_pkg::VEC_OS:      dec.svc = brvm_pkg::SVC_OS;
        brvm_pkg::VEC_EXIT:    dec.ext = 1'b1;
        default:               dec.svc = brvm_pkg::SVC_NONE;
      endcase
    end
  end

  assign in_stall = (count == 2'd2);
  assign push = in_valid && !in_stall;
  assign pop = q_pop && q_valid;
  assign q_valid = (count != 2'd0);
  assign q_data = q_mem[rd_ptr];

  // Queue storage and pointers.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= dec;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### src/brvm_div.sv
// Restoring 8-bit divider, one quotient bit per cycle.
module brvm_div (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] dividend,
  input  logic [7:0] divisor,
  output logic       done,
  output logic [7:0] quotient
);

  logic       busy;
  logic [7:0] rem;
  logic [7:0] quo;
  logic [7:0] dvs;
  logic [3:0] cnt;
  logic [8:0] trial;

  assign trial = {rem[7:0], quo[7]} - {1'b0, dvs};
  assign quotient = quo;

  // One shift-subtract step each cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 4'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 4'd8;
        rem  <= 8'd0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        if (!trial[8]) begin
          rem <= trial[7:0];
          quo <= {quo[6:0], 1'b1};
        end else begin
          rem <= {rem[6:0], quo[7]};
          quo <= {quo[6:0], 1'b0};
        end
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### src/brvm_back.sv
// Back end: executes queued instructions against the machine state and emits results.
module brvm_back #(
  parameter int STACK_DEPTH  = 128,
  parameter longint PROGRAM_SIZE = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_pop,
  input  brvm_pkg::dec_item_t q_data,
  input  logic [31:0]         heap_base,
  input  logic [31:0]         heap_limit,
  output logic                out_valid,
  input  logic                out_stall,
  output brvm_pkg::out_item_t out_data
);

  localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [SW-1:0] TOP = SW'(STACK_DEPTH - 1);
  localparam logic [32:0] PSIZE = 33'(PROGRAM_SIZE);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_EXEC = 4'b0010, S_DIV = 4'b0100, S_POP = 4'b1000
  } state_t;

  state_t state;
  logic [7:0] regs [8];
  logic [7:0] stack_mem [STACK_DEPTH];
  logic [SW-1:0] stack_index;
  logic [31:0] prog_counter;
  logic [31:0] return_pc;
  logic equal_flag;
  logic greater_flag;
  logic int_enable;
  logic [7:0] stack_rd;
  logic clearing;
  logic [SW-1:0] clr_idx;

  brvm_pkg::in_item_t it;
  brvm_pkg::out_item_t res;
  logic [31:0] nxt;
  logic [7:0] ra, rb, rc;
  logic [15:0] prod;
  logic [SW-1:0] pop_idx;
  logic div_start, div_done;
  logic [7:0] div_q;
  logic issue;

  assign it = q_data.item;
  assign ra = regs[it.dst];
  assign rb = regs[it.src_one];
  assign rc = regs[it.src_two];
  assign prod = rb * rc;
  assign pop_idx = (stack_index == '0) ? TOP : stack_index - SW'(1);

  // An item may run when the output register is free.
  assign issue = (state == S_EXEC) && (!out_valid || !out_stall);
  assign div_start = (state == S_IDLE) && !clearing && q_valid && q_data.is_div &&
                     (rc != 8'd0);

  brvm_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(rb), .divisor(rc),
    .done(div_done), .quotient(div_q)
  );

  // Next pc and the side outputs of one instruction.
  always_comb begin
    nxt = prog_counter + 32'd1;
    res = '0;
    case (brvm_pkg::op_t'(it.op))
      brvm_pkg::OP_MOVMR, brvm_pkg::OP_MOVMW: begin
        res.mem_address = heap_base + it.target;
        if (it.target > heap_limit) begin
          res.seg_fault = 1'b1;
          nxt = prog_counter;
        end else begin
          res.mem_read  = (it.op == brvm_pkg::OP_MOVMR);
          res.mem_write = (it.op == brvm_pkg::OP_MOVMW);
          if (it.op == brvm_pkg::OP_MOVMW) res.store_data = ra;
          nxt = prog_counter + 32'd6;
        end
      end
      brvm_pkg::OP_MOVA: nxt = prog_counter + 32'd6;
      brvm_pkg::OP_MUL, brvm_pkg::OP_DIV: nxt = prog_counter + 32'd4;
      brvm_pkg::OP_INC, brvm_pkg::OP_DEC, brvm_pkg::OP_POP, brvm_pkg::OP_PUSH,
      brvm_pkg::OP_SWI: nxt = prog_counter + 32'd2;
      brvm_pkg::OP_MOVR, brvm_pkg::OP_MOVB, brvm_pkg::OP_ADD, brvm_pkg::OP_SUB,
      brvm_pkg::OP_AND, brvm_pkg::OP_OR, brvm_pkg::OP_XOR, brvm_pkg::OP_NOT,
      brvm_pkg::OP_CMP, brvm_pkg::OP_CMPR: nxt = prog_counter + 32'd3;
      brvm_pkg::OP_JMP, brvm_pkg::OP_CALL: nxt = it.target;
      brvm_pkg::OP_JE:  nxt = equal_flag ? it.target : prog_counter + 32'd5;
      brvm_pkg::OP_JNE: nxt = !equal_flag ? it.target : prog_counter + 32'd5;
      brvm_pkg::OP_JG:  nxt = greater_flag ? it.target : prog_counter + 32'd5;
      brvm_pkg::OP_JL:  nxt = !greater_flag ? it.target : prog_counter + 32'd5;
      brvm_pkg::OP_RET: nxt = return_pc;
      default: nxt = prog_counter + 32'd1;
    endcase
    res.next_pc = nxt;
    res.service = q_data.svc;
    res.exit_to_host = q_data.ext;
    res.irq_enable = (it.op == brvm_pkg::OP_STI) ? 1'b1 :
                     (it.op == brvm_pkg::OP_CLI) ? 1'b0 : int_enable;
    res.program_end = ({1'b0, nxt} >= PSIZE);
  end

  assign q_pop = issue;

  // Stack clearing pass after reset, one entry per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + SW'(1);
      if (clr_idx == TOP) clearing <= 1'b0;
    end
  end

  // Stack memory: registered read of the entry below the top, write on push.
  always_ff @(posedge clk) begin
    stack_rd <= stack_mem[pop_idx];
    if (clearing) begin
      stack_mem[clr_idx] <= 8'd0;
    end else if (issue && it.op == brvm_pkg::OP_PUSH) begin
      stack_mem[stack_index] <= ra;
    end
  end

  // Sequencer and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < 8; i++) regs[i] <= 8'd0;
      stack_index <= '0;
      prog_counter <= 32'd0;
      return_pc <= 32'd0;
      equal_flag <= 1'b0;
      greater_flag <= 1'b0;
      int_enable <= 1'b0;
    end else begin
      if (issue) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid && !clearing) begin
            if (div_start) state <= S_DIV;
            else if (it.op == brvm_pkg::OP_POP) state <= S_POP;
            else state <= S_EXEC;
          end
        end
        S_DIV: if (div_done) state <= S_EXEC;
        S_POP: state <= S_EXEC;
        S_EXEC: begin
          if (issue) begin
            state <= S_IDLE;
            out_data <= res;
            prog_counter <= nxt;
            int_enable <= res.irq_enable;
            case (brvm_pkg::op_t'(it.op))
              brvm_pkg::OP_MOVMR: if (!res.seg_fault) regs[it.dst] <= it.load_data;
              brvm_pkg::OP_MOVR: regs[it.dst] <= rb;
              brvm_pkg::OP_MOVB: regs[it.dst] <= it.imm_low;
              brvm_pkg::OP_MOVA: begin
                regs[it.dst] <= it.imm_low;
                regs[it.dst + 3'd1] <= it.imm_high;
              end
              brvm_pkg::OP_INC: regs[it.dst] <= ra + 8'd1;
              brvm_pkg::OP_DEC: regs[it.dst] <= ra - 8'd1;
              brvm_pkg::OP_ADD: regs[it.dst] <= ra + rb;
              brvm_pkg::OP_SUB: regs[it.dst] <= ra - rb;
              brvm_pkg::OP_MUL: regs[it.dst] <= prod[7:0];
              brvm_pkg::OP_DIV: regs[it.dst] <= (rc == 8'd0) ? 8'hFF : div_q;
              brvm_pkg::OP_POP: begin
                regs[it.dst] <= stack_rd;
                stack_index <= pop_idx;
              end
              brvm_pkg::OP_PUSH:
                stack_index <= (stack_index == TOP) ? '0 : stack_index + SW'(1);
              brvm_pkg::OP_AND: regs[it.dst] <= ra & rb;
              brvm_pkg::OP_OR:  regs[it.dst] <= ra | rb;
              brvm_pkg::OP_XOR: regs[it.dst] <= ra ^ rb;
              brvm_pkg::OP_NOT: regs[it.dst] <= ~ra;
              brvm_pkg::OP_CMP: begin
                equal_flag <= (ra == it.imm_low);
                greater_flag <= (ra > it.imm_low);
              end
              brvm_pkg::OP_CMPR: begin
                equal_flag <= (ra == rb);
                greater_flag <= (ra > rb);
              end
              brvm_pkg::OP_CALL: return_pc <= prog_counter + 32'd5;
              brvm_pkg::OP_RET: return_pc <= 32'd0;
              default: ;
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/byte_register_vm_execute_top.sv
// Top level of the byte register VM executor: configuration, front end and back end.
//
// Each instruction passes through the back end states IDLE (queue read) and EXEC
// (execute and register the result); POP adds a POP state because the stack memory
// has a registered read port, and DIV with a nonzero divisor waits in a DIV state
// for the bit-serial divider. After reset the back end clears all
// STACK_DEPTH entries (128 by default) of the stack memory before it runs the first
// instruction. A two-entry queue lets the front end take items while the back end is busy,
// and the output register holds a result while the next one is prepared.
module byte_register_vm_execute_top #(
  parameter int STACK_DEPTH = 128,
  parameter longint PROGRAM_SIZE = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  brvm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output brvm_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  logic [31:0] heap_base;
  logic [31:0] heap_limit;
  logic q_valid;
  logic q_pop;
  brvm_pkg::dec_item_t q_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= 32'd0;
      heap_limit <= 32'hFFFF_FFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        brvm_pkg::CFG_HEAP_BASE:  heap_base  <= cfg_data;
        brvm_pkg::CFG_HEAP_LIMIT: heap_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  brvm_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
  );

  brvm_back #(.STACK_DEPTH(STACK_DEPTH), .PROGRAM_SIZE(PROGRAM_SIZE)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
    .heap_base(heap_base), .heap_limit(heap_limit),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // A faulting access never requests memory.
  a_fault_no_req: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.seg_fault |-> !out_data.mem_read && !out_data.mem_write)
    else $error("memory request on segment fault");

  // The queue is only popped when it holds an item.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("queue popped while empty");

  // A result is registered only when the output is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("pending result overwritten");

endmodule
